// ===== rtl/core/desbm_pkg.sv =====
// ----------------------------------------------------------------------------
// desbm_pkg
// types, constants and permutation functions for the des block-mode core
// ----------------------------------------------------------------------------
package desbm_pkg;

  localparam int unsigned NumRounds   = 16;
  localparam int unsigned HalfKeyBits = 28;
  localparam int unsigned RkBits      = 48;
  localparam int unsigned SegBits     = 8;

  typedef logic [3:0] round_idx_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CFB = 2'd2,
    MODE_OFB = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_KEY  = 2'd0,
    REG_IV   = 2'd1,
    REG_MODE = 2'd2,
    REG_DEC  = 2'd3
  } reg_idx_t;

  // key schedule control between top level and round-key memory
  typedef struct packed {
    logic       busy;
    logic       wr;
    round_idx_t idx;
  } ks_stat_t;

  // tables in standard numbering: entry value 1 is msb of the input
  localparam byte unsigned IP_T[64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned FP_T[64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned E_T[48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam byte unsigned P_T[32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam byte unsigned PC1_T[56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam byte unsigned PC2_T[48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [15:0] ROT2_T = 16'b0111_1110_1111_1100; // bit j: shift 2 in round j

  localparam logic [3:0] SBOX_T[8][64] = '{
  '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
    4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
  '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
    0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
  '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
    13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
  '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
    10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
  '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
    4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
  '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
    9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
  '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
    1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
  '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
    7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v, input logic fin);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = fin ? v[64-FP_T[i]] : v[64-IP_T[i]];
    end
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] k);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) begin
      r[55-i] = k[64-PC1_T[i]];
    end
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] cd);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = cd[56-PC2_T[i]];
    end
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input logic two);
    return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) begin
      x[47-i] = r[32-E_T[i]];
    end
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX_T[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      p[31-i] = s[32-P_T[i]];
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/desbm_rkmem.sv =====
// ----------------------------------------------------------------------------
// desbm_rkmem
// round-key memory, 16 x 48, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module desbm_rkmem (
  input  logic                   clk,
  input  desbm_pkg::ks_stat_t    ks,
  input  logic [47:0]            wr_data,
  input  desbm_pkg::round_idx_t  rd_idx,
  output logic [47:0]            rd_data
);

  logic [47:0] mem [16];

  always_ff @(posedge clk) begin
    if (ks.wr) begin
      mem[ks.idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

// ===== rtl/core/desbm_keysched.sv =====
// ----------------------------------------------------------------------------
// desbm_keysched
// sequential key schedule: one round key per cycle into the key memory
// ----------------------------------------------------------------------------
module desbm_keysched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          key,
  output desbm_pkg::ks_stat_t  ks,
  output logic [47:0]          rk
);

  logic [27:0] c_r, d_r, c_nxt, d_nxt;
  logic [3:0]  idx_r;
  logic        busy_r;
  logic [55:0] cd0;
  logic        two;

  assign cd0   = desbm_pkg::perm_pc1(key);
  assign two   = desbm_pkg::ROT2_T[idx_r];
  assign c_nxt = desbm_pkg::rot28(c_r, two);
  assign d_nxt = desbm_pkg::rot28(d_r, two);
  assign rk    = desbm_pkg::perm_pc2({c_nxt, d_nxt});
  assign ks    = '{busy: busy_r | start, wr: busy_r, idx: idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      c_r    <= '0;
      d_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      c_r    <= cd0[55:28];
      d_r    <= cd0[27:0];
    end else if (busy_r) begin
      c_r   <= c_nxt;
      d_r   <= d_nxt;
      idx_r <= idx_r + 4'd1;
      if (idx_r == 4'd15) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/des_cipher_with_block_modes_core.sv =====
// ----------------------------------------------------------------------------
// des_cipher_with_block_modes_core
// des engine with ecb, cbc, cfb-8 and ofb-8 chaining
// ----------------------------------------------------------------------------
// channel | direction | ports                          | accepted when
// in      | input     | in_valid, in_stall, in_data_in, | in_valid && !in_stall
//         |           | in_first_item                  |
// out     | output    | out_valid, out_stall, out_data_out | out_valid && !out_stall
// cfg     | input     | cfg_we, cfg_idx, cfg_wdata     | cfg_we
//
// one transaction runs as a read of the first round key, sixteen
// rounds each fed by a registered read of the round-key memory, then the
// final permutation into the output register
// after reset and after each key write the schedule fills the round-key
// memory, one round key at a time; no input transaction is taken meanwhile
// a new input is taken while the output register waits, only after the
// result is drained by the consumer can the following result be stored
// ----------------------------------------------------------------------------
module des_cipher_with_block_modes_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_in,
  input  logic        in_first_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t          state_r;
  logic [63:0]     iv_r, chain_r, din_r;
  desbm_pkg::mode_t mode_r;
  logic            dec_r, edec_r;
  logic [31:0]     l_r, r_r;
  logic [4:0]      cnt_r;
  logic [63:0]     res_r;
  logic            ovalid_r;

  desbm_pkg::ks_stat_t   ks;
  logic [47:0]           ks_rk, rk_rd;
  desbm_pkg::round_idx_t rd_idx;
  logic                  key_wr;

  logic        in_acc, out_acc, done_go;
  logic [63:0] chain_use, blk_in, ip_v, fp_v, res_nxt, chain_nxt;
  logic [7:0]  ks_byte, res_byte;

  assign key_wr = cfg_we && (cfg_idx == desbm_pkg::REG_KEY);

  desbm_keysched u_ks (
    .clk(clk), .rst_n(rst_n), .start(key_wr), .key(cfg_wdata),
    .ks(ks), .rk(ks_rk)
  );

  // round index into memory: key for the next round, reversed when decrypting
  logic [3:0] nxt_round;
  logic       edec_r_sel;
  assign nxt_round = (state_r == ST_IDLE) ? 4'd0 : cnt_r[3:0] + 4'd1;
  assign rd_idx    = edec_r_sel ? ~nxt_round : nxt_round;

  desbm_rkmem u_mem (
    .clk(clk), .ks(ks), .wr_data(ks_rk), .rd_idx(rd_idx), .rd_data(rk_rd)
  );

  assign in_stall = (state_r != ST_IDLE) || ks.busy;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ovalid_r && !out_stall;
  // result leaves the engine once the output register is free or draining
  assign done_go  = (state_r == ST_DONE) && (!ovalid_r || out_acc);
  assign out_valid    = ovalid_r;
  assign out_data_out = res_r;

  // engine direction: feedback byte modes always run the encrypt direction
  logic in_edec;
  assign in_edec    = dec_r && ((mode_r == desbm_pkg::MODE_ECB) ||
                                (mode_r == desbm_pkg::MODE_CBC));
  assign edec_r_sel = (state_r == ST_IDLE) ? in_edec : edec_r;

  // input block selection, chain reload on message start
  always_comb begin
    chain_use = in_first_item ? iv_r : chain_r;
    case (mode_r)
      desbm_pkg::MODE_ECB: blk_in = in_data_in;
      desbm_pkg::MODE_CBC: blk_in = dec_r ? in_data_in : (in_data_in ^ chain_use);
      default:             blk_in = chain_use;
    endcase
  end

  assign ip_v = desbm_pkg::perm_ip(blk_in, 1'b0);
  assign fp_v = desbm_pkg::perm_ip({r_r, l_r}, 1'b1);

  // mode post-processing after the final permutation
  always_comb begin
    ks_byte   = fp_v[63:56];
    res_byte  = din_r[7:0] ^ ks_byte;
    res_nxt   = fp_v;
    chain_nxt = chain_r;
    case (mode_r)
      desbm_pkg::MODE_ECB: begin
        res_nxt = fp_v;
      end
      desbm_pkg::MODE_CBC: begin
        if (dec_r) begin
          res_nxt   = fp_v ^ chain_r;
          chain_nxt = din_r;
        end else begin
          res_nxt   = fp_v;
          chain_nxt = fp_v;
        end
      end
      desbm_pkg::MODE_CFB: begin
        res_nxt   = {56'd0, res_byte};
        chain_nxt = {chain_r[55:0], dec_r ? din_r[7:0] : res_byte};
      end
      default: begin
        res_nxt   = {56'd0, res_byte};
        chain_nxt = {chain_r[55:0], ks_byte};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= '0;
      mode_r   <= desbm_pkg::MODE_ECB;
      dec_r    <= 1'b0;
      chain_r  <= '0;
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      edec_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          desbm_pkg::REG_KEY:  ;  // key feeds the round-key schedule directly
          desbm_pkg::REG_IV:   iv_r   <= cfg_wdata;
          desbm_pkg::REG_MODE: mode_r <= desbm_pkg::mode_t'(cfg_wdata[1:0]);
          desbm_pkg::REG_DEC:  dec_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (done_go) begin
        ovalid_r <= 1'b1;
      end else if (out_acc) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // first key read issued this cycle, lands with the round counter at 0
            chain_r <= in_first_item ? iv_r : chain_r;
            edec_r  <= in_edec;
            cnt_r   <= '0;
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold here while the previous result still waits
          if (done_go) begin
            chain_r <= chain_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      din_r <= in_data_in;
      l_r   <= ip_v[63:32];
      r_r   <= ip_v[31:0];
    end else if (state_r == ST_ROUND) begin
      l_r <= r_r;
      r_r <= l_r ^ desbm_pkg::feistel(r_r, rk_rd);
    end
    if (done_go) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/desbm_checker.sv =====
// ----------------------------------------------------------------------------
// desbm_checker
// port-level checks on the des block-mode core
// ----------------------------------------------------------------------------
module desbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_data_out
);

  // one item in flight: accept blocks input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // sixteen rounds and the final permutation keep the input blocked
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall [*17])
    else $error("input taken before the rounds finished");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data_out)))
    else $error("stalled result changed");

  // a presented result is always fully defined
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data_out))
    else $error("result has unknown bits");

endmodule

bind des_cipher_with_block_modes_core desbm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data_out(out_data_out)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the des block-mode core: a directed table walks
// the known des vectors and every chaining mode, then random messages run
// under random stalls on both channels against a bit-accurate predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 40;   // outlasts a transaction and the key fill
  localparam int unsigned RandItems    = 430;
  localparam int unsigned QuietFrom    = 370;  // no idling from here on

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_data_in;
  logic        in_first_item;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_data_out;

  des_cipher_with_block_modes_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_in   (in_data_in),
    .in_first_item(in_first_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out)
  );

  // ---------------------------------------------------------------- predictor
  // shadow of the block's registers and chaining state
  logic [63:0]      key_q;
  logic [63:0]      iv_q;
  desbm_pkg::mode_t mode_q;
  logic             dec_q;
  logic [63:0]      chain_q;
  logic [47:0]      subkey[16];

  // rotation amount per round of the key schedule
  localparam int ShiftAmt[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  logic [63:0] cipher_q[$];   // expected data_out, oldest first
  int          errors;
  int          n_results;
  int          mode_hits[4];
  bit          quiet;
  int unsigned cycles;

  function automatic void build_subkeys(input logic [63:0] k);
    logic [55:0] cd;
    logic [27:0] c, d;
    for (int i = 0; i < 56; i++) cd[55-i] = k[64-desbm_pkg::PC1_T[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int j = 0; j < 16; j++) begin
      for (int s = 0; s < ShiftAmt[j]; s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) subkey[j][47-i] = cd[56-desbm_pkg::PC2_T[i]];
    end
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s, p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-desbm_pkg::E_T[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = desbm_pkg::SBOX_T[i][{six[5], six[0]} * 16 + six[4:1]];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-desbm_pkg::P_T[i]];
    return p;
  endfunction

  function automatic logic [63:0] des_crypt(input logic [63:0] blk, input logic dec);
    logic [63:0] v, o;
    logic [31:0] l, r, t;
    for (int i = 0; i < 64; i++) v[63-i] = blk[64-desbm_pkg::IP_T[i]];
    l = v[63:32];
    r = v[31:0];
    for (int i = 0; i < 16; i++) begin
      t = l ^ round_fn(r, subkey[dec ? 15 - i : i]);
      l = r;
      r = t;
    end
    v = {r, l};
    for (int i = 0; i < 64; i++) o[63-i] = v[64-desbm_pkg::FP_T[i]];
    return o;
  endfunction

  // advance the shadow state by one input transaction, return its result
  function automatic logic [63:0] cipher_step(input logic [63:0] d, input logic first);
    logic [63:0] res;
    logic [63:0] enc;
    logic [7:0]  ks, db;
    if (first) chain_q = iv_q;
    mode_hits[mode_q]++;
    case (mode_q)
      desbm_pkg::MODE_ECB: res = des_crypt(d, dec_q);
      desbm_pkg::MODE_CBC: begin
        if (dec_q) begin
          res = des_crypt(d, 1'b1) ^ chain_q;
          chain_q = d;
        end else begin
          res = des_crypt(d ^ chain_q, 1'b0);
          chain_q = res;
        end
      end
      desbm_pkg::MODE_CFB: begin
        enc = des_crypt(chain_q, 1'b0);
        ks = enc[63:56];
        db = d[7:0];
        res = {56'd0, db ^ ks};
        chain_q = {chain_q[55:0], dec_q ? db : res[7:0]};
      end
      default: begin
        enc = des_crypt(chain_q, 1'b0);
        ks = enc[63:56];
        res = {56'd0, d[7:0] ^ ks};
        chain_q = {chain_q[55:0], ks};
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // ---------------------------------------------------------------- clock, limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- result side
  int unsigned stall_left;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_out, 'x);
      end else begin
        logic [63:0] want;
        want = cipher_q.pop_front();
        n_results++;
        if (out_data_out !== want) report_mismatch("data_out", out_data_out, want);
      end
    end
    // random stall bursts on the consumer side
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- input side
  // register write, only with nothing in flight
  task automatic cfg_write(input desbm_pkg::reg_idx_t idx, input logic [63:0] val);
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      desbm_pkg::REG_KEY:  begin key_q = val; build_subkeys(val); end
      desbm_pkg::REG_IV:   iv_q = val;
      desbm_pkg::REG_MODE: mode_q = desbm_pkg::mode_t'(val[1:0]);
      default:             dec_q = val[0];
    endcase
  endtask

  // one input transaction; a fixed expectation overrides the predictor
  task automatic send_item(input logic [63:0] d, input logic first,
                           input bit fixed, input logic [63:0] want);
    logic [63:0] pred;
    in_data_in    <= d;
    in_first_item <= first;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = cipher_step(d, first);
    cipher_q.push_back(fixed ? want : pred);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  typedef struct {
    desbm_pkg::mode_t mode;
    logic             dec;
    logic [63:0]      key;
    logic [63:0]      iv;
    logic [63:0]      data;
    logic             first;
    bit               fixed;
    logic [63:0]      want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(desbm_pkg::mode_t m, logic dc, logic [63:0] k,
                                  logic [63:0] v, logic [63:0] d, logic f, bit fx,
                                  logic [63:0] w);
    dir_row_t r;
    r = '{m, dc, k, v, d, f, fx, w};
    dir_rows.push_back(r);
  endfunction

  localparam logic [63:0] KeyA  = 64'h1334_5779_9BBC_DFF1;
  localparam logic [63:0] IvA   = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] Ones  = '1;

  initial begin
    logic [63:0] k, v, d;
    int          msg_len;
    int          sent;

    cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    in_valid = 0; in_data_in = '0; in_first_item = 0;
    out_stall = 0; stall_left = 0; quiet = 0;
    errors = 0; n_results = 0; cycles = 0;
    for (int i = 0; i < 4; i++) mode_hits[i] = 0;
    key_q = '0; iv_q = '0; mode_q = desbm_pkg::MODE_ECB; dec_q = 0; chain_q = '0;
    build_subkeys('0);

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: all-zero key, ecb encrypt of zero
    add_row(desbm_pkg::MODE_ECB, 0, '0, '0, '0, 0, 1, 64'h8CA6_4DE9_C1B1_23A7);
    add_row(desbm_pkg::MODE_ECB, 0, KeyA, '0, IvA, 0, 1, 64'h85E8_1354_0F0A_B405);
    add_row(desbm_pkg::MODE_ECB, 1, KeyA, '0, 64'h85E8_1354_0F0A_B405, 0, 1, IvA);
    add_row(desbm_pkg::MODE_ECB, 0, Ones, '0, Ones, 0, 1, 64'h7359_B216_3E4E_DC58);
    // ecb with first_item: chain reloads but is unused
    add_row(desbm_pkg::MODE_ECB, 0, Ones, Ones, '0, 1, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 0, KeyA, IvA, 64'h4E6F_7720_6973_2074, 1, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 0, KeyA, IvA, 64'h6865_2074_696D_6520, 0, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 0, KeyA, IvA, Ones, 0, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 1, KeyA, IvA, 64'hDEAD_BEEF_0BAD_F00D, 1, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 1, KeyA, IvA, '0, 0, 0, '0);
    // mode switch mid-message keeps the chain
    add_row(desbm_pkg::MODE_ECB, 1, KeyA, IvA, 64'h1111_2222_3333_4444, 0, 0, '0);
    add_row(desbm_pkg::MODE_CBC, 1, KeyA, IvA, 64'h5555_6666_7777_8888, 0, 0, '0);
    // byte modes with the upper data bits set: ignored
    add_row(desbm_pkg::MODE_CFB, 0, KeyA, IvA, 64'hFFFF_FFFF_FFFF_FF00, 1, 0, '0);
    add_row(desbm_pkg::MODE_CFB, 0, KeyA, IvA, 64'hA5A5_A5A5_A5A5_A5FF, 0, 0, '0);
    add_row(desbm_pkg::MODE_CFB, 1, KeyA, IvA, 64'h0000_0000_0000_0055, 1, 0, '0);
    add_row(desbm_pkg::MODE_CFB, 1, KeyA, IvA, Ones, 0, 0, '0);
    // ofb: direction bit has no effect
    add_row(desbm_pkg::MODE_OFB, 0, KeyA, IvA, 64'hFFFF_FFFF_FFFF_FF3C, 1, 0, '0);
    add_row(desbm_pkg::MODE_OFB, 0, KeyA, IvA, '0, 0, 0, '0);
    add_row(desbm_pkg::MODE_OFB, 1, KeyA, IvA, 64'h0000_0000_0000_003C, 1, 0, '0);
    add_row(desbm_pkg::MODE_OFB, 1, Ones, Ones, 64'h0000_0000_0000_00C3, 1, 0, '0);
    // key change mid-message
    add_row(desbm_pkg::MODE_OFB, 1, '0, Ones, 64'h0000_0000_0000_0081, 0, 0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].key  !== key_q)  cfg_write(desbm_pkg::REG_KEY, dir_rows[i].key);
      if (dir_rows[i].iv   !== iv_q)   cfg_write(desbm_pkg::REG_IV, dir_rows[i].iv);
      if (dir_rows[i].mode !== mode_q)
        cfg_write(desbm_pkg::REG_MODE, 64'(dir_rows[i].mode));
      if (dir_rows[i].dec  !== dec_q)
        cfg_write(desbm_pkg::REG_DEC, 64'(dir_rows[i].dec));
      send_item(dir_rows[i].data, dir_rows[i].first, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random messages, each after random rewrites of key, iv, mode and direction
    sent = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 5))
        0:       k = '0;
        1:       k = Ones;
        default: k = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = Ones;
        default: v = {$urandom, $urandom};
      endcase
      if (sent == 0 || $urandom_range(0, 1)) cfg_write(desbm_pkg::REG_KEY, k);
      if (sent == 0 || $urandom_range(0, 1)) cfg_write(desbm_pkg::REG_IV, v);
      if (sent == 0 || $urandom_range(0, 3))
        cfg_write(desbm_pkg::REG_MODE, 64'($urandom_range(0, 3)));
      if (sent == 0 || $urandom_range(0, 1))
        cfg_write(desbm_pkg::REG_DEC, 64'($urandom_range(0, 1)));
      msg_len = $urandom_range(1, 20);
      for (int j = 0; j < msg_len && sent < RandItems; j++) begin
        d = {$urandom, $urandom};
        if (sent >= QuietFrom) quiet = 1;
        // most messages start cleanly, a few skip the restart or restart midway
        send_item(d, (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0),
                  0, '0);
        sent++;
      end
    end
    quiet = 1;
    in_valid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d results: ecb %0d, cbc %0d, cfb-8 %0d, ofb-8 %0d transactions",
             n_results, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("both directions, key and iv extremes, restarts and mid-message changes");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
